### rtl/mips_ex_pkg.sv
// ----------------------------------------------------------------------------
// mips_ex_pkg
// Types shared by the MIPS32 execute stage: control word and its codes.
// ----------------------------------------------------------------------------
package mips_ex_pkg;

  typedef enum logic [3:0] {
    ALU_NONE  = 4'd0,
    ALU_ADD   = 4'd1,
    ALU_SUB   = 4'd2,
    ALU_AND   = 4'd3,
    ALU_OR    = 4'd4,
    ALU_XOR   = 4'd5,
    ALU_NOR   = 4'd6,
    ALU_SLL   = 4'd7,
    ALU_SRL   = 4'd8,
    ALU_SRA   = 4'd9,
    ALU_SLT   = 4'd10,
    ALU_SLTU  = 4'd11,
    ALU_PASSB = 4'd12,
    ALU_LINK  = 4'd13
  } alu_op_e;

  // Source of the ALU's second operand
  typedef enum logic [1:0] {
    OPB_RT   = 2'd0,
    OPB_SIMM = 2'd1,
    OPB_ZIMM = 2'd2,
    OPB_LUI  = 2'd3
  } opb_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } mem_size_e;

  typedef enum logic [2:0] {
    FLOW_NONE = 3'd0,
    FLOW_BEQ  = 3'd1,
    FLOW_BNE  = 3'd2,
    FLOW_JUMP = 3'd3,
    FLOW_JREG = 3'd4
  } flow_e;

  typedef struct packed {
    alu_op_e    alu_op;
    opb_e       opb;
    logic       shift_var;
    logic [4:0] dest_reg;
    logic       reg_write;
    mem_op_e    mem_op;
    mem_size_e  mem_size;
    logic       load_signed;
    flow_e      flow;
    logic       illegal;
  } ctrl_t;

endpackage

### rtl/mips_execute_stage.sv
// ----------------------------------------------------------------------------
// mips_execute_stage
// MIPS32 integer execute stage: decode, ALU, address and branch resolution.
// ----------------------------------------------------------------------------
// One instruction is taken per cycle whenever start_i is high (busy_o is
// always low) and its result beat appears on the result ports, flagged by
// done_o, once it has passed the registered stages: decode and operand
// select, then ALU / address / target adders, then field masking into the
// output registers. Results are shown for one cycle only and cannot be held
// off, so the receiver must take every beat as it comes.
module mips_execute_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] rs_data_i,
  input  logic [31:0] rt_data_i,
  input  logic [31:0] pc_i,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic [4:0]  dest_reg_o,
  output logic        reg_write_o,
  output logic [1:0]  mem_op_o,
  output logic [1:0]  mem_size_o,
  output logic        load_signed_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] store_data_o,
  output logic        redirect_o,
  output logic [31:0] target_pc_o,
  output logic        illegal_o
);
  import mips_ex_pkg::*;

  // ---------------- stage 1: decode and operand select ----------------
  ctrl_t       dec_ctrl;
  logic [31:0] simm;
  logic [31:0] opb_d;
  logic [4:0]  shamt_d;

  logic        v1_q;
  ctrl_t       ctrl1_q;
  logic [31:0] a1_q;
  logic [31:0] b1_q;
  logic [31:0] rt1_q;
  logic [31:0] pc4_1_q;
  logic [31:0] simm1_q;
  logic [25:0] jidx1_q;
  logic [4:0]  shamt1_q;

  mips_ex_decode u_decode (
    .instr_i (instruction_i),
    .ctrl_o  (dec_ctrl)
  );

  assign simm = {{16{instruction_i[15]}}, instruction_i[15:0]};

  always_comb begin
    case (dec_ctrl.opb)
      OPB_RT:   opb_d = rt_data_i;
      OPB_SIMM: opb_d = simm;
      OPB_ZIMM: opb_d = {16'h0000, instruction_i[15:0]};
      OPB_LUI:  opb_d = {instruction_i[15:0], 16'h0000};
      default:  opb_d = rt_data_i;
    endcase
    shamt_d = dec_ctrl.shift_var ? rs_data_i[4:0] : instruction_i[10:6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ctrl1_q  <= dec_ctrl;
      a1_q     <= rs_data_i;
      b1_q     <= opb_d;
      rt1_q    <= rt_data_i;
      pc4_1_q  <= pc_i + 32'd4;
      simm1_q  <= simm;
      jidx1_q  <= instruction_i[25:0];
      shamt1_q <= shamt_d;
    end
  end

  // ---------------- stage 2: ALU, address and target ----------------
  logic [31:0] res_d;
  logic [31:0] tgt_d;
  logic        taken_d;

  logic        v2_q;
  ctrl_t       ctrl2_q;
  logic [31:0] res2_q;
  logic [31:0] addr2_q;
  logic [31:0] tgt2_q;
  logic        taken2_q;
  logic [31:0] rt2_q;

  always_comb begin
    case (ctrl1_q.alu_op)
      ALU_ADD:   res_d = a1_q + b1_q;
      ALU_SUB:   res_d = a1_q - b1_q;
      ALU_AND:   res_d = a1_q & b1_q;
      ALU_OR:    res_d = a1_q | b1_q;
      ALU_XOR:   res_d = a1_q ^ b1_q;
      ALU_NOR:   res_d = ~(a1_q | b1_q);
      ALU_SLL:   res_d = b1_q << shamt1_q;
      ALU_SRL:   res_d = b1_q >> shamt1_q;
      ALU_SRA:   res_d = 32'($signed(b1_q) >>> shamt1_q);
      ALU_SLT:   res_d = {31'd0, $signed(a1_q) < $signed(b1_q)};
      ALU_SLTU:  res_d = {31'd0, a1_q < b1_q};
      ALU_PASSB: res_d = b1_q;
      ALU_LINK:  res_d = pc4_1_q;
      default:   res_d = '0;
    endcase
  end

  always_comb begin
    case (ctrl1_q.flow)
      FLOW_BEQ: begin
        tgt_d   = pc4_1_q + {simm1_q[29:0], 2'b00};
        taken_d = (a1_q == rt1_q);
      end
      FLOW_BNE: begin
        tgt_d   = pc4_1_q + {simm1_q[29:0], 2'b00};
        taken_d = (a1_q != rt1_q);
      end
      FLOW_JUMP: begin
        tgt_d   = {pc4_1_q[31:28], jidx1_q, 2'b00};
        taken_d = 1'b1;
      end
      FLOW_JREG: begin
        tgt_d   = a1_q;
        taken_d = 1'b1;
      end
      default: begin
        tgt_d   = '0;
        taken_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      ctrl2_q  <= ctrl1_q;
      res2_q   <= res_d;
      addr2_q  <= a1_q + simm1_q;
      tgt2_q   <= tgt_d;
      taken2_q <= taken_d;
      rt2_q    <= rt1_q;
    end
  end

  // ---------------- stage 3: field masking into output registers ----------------
  logic [31:0] sdata_d;

  logic        done_q;
  logic [31:0] result_q;
  logic [4:0]  dest_reg_q;
  logic        reg_write_q;
  logic [1:0]  mem_op_q;
  logic [1:0]  mem_size_q;
  logic        load_signed_q;
  logic [31:0] mem_address_q;
  logic [31:0] store_data_q;
  logic        redirect_q;
  logic [31:0] target_pc_q;
  logic        illegal_q;

  always_comb begin
    if (ctrl2_q.mem_op == MEM_STORE) begin
      case (ctrl2_q.mem_size)
        SIZE_BYTE: sdata_d = {24'd0, rt2_q[7:0]};
        SIZE_HALF: sdata_d = {16'd0, rt2_q[15:0]};
        default:   sdata_d = rt2_q;
      endcase
    end else begin
      sdata_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      result_q      <= res2_q;
      dest_reg_q    <= ctrl2_q.dest_reg;
      reg_write_q   <= ctrl2_q.reg_write;
      mem_op_q      <= ctrl2_q.mem_op;
      mem_size_q    <= ctrl2_q.mem_size;
      load_signed_q <= ctrl2_q.load_signed;
      mem_address_q <= (ctrl2_q.mem_op != MEM_NONE) ? addr2_q : '0;
      store_data_q  <= sdata_d;
      redirect_q    <= taken2_q;
      target_pc_q   <= tgt2_q;
      illegal_q     <= ctrl2_q.illegal;
    end
  end

  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign result_o      = result_q;
  assign dest_reg_o    = dest_reg_q;
  assign reg_write_o   = reg_write_q;
  assign mem_op_o      = mem_op_q;
  assign mem_size_o    = mem_size_q;
  assign load_signed_o = load_signed_q;
  assign mem_address_o = mem_address_q;
  assign store_data_o  = store_data_q;
  assign redirect_o    = redirect_q;
  assign target_pc_o   = target_pc_q;
  assign illegal_o     = illegal_q;

endmodule

### rtl/mips_ex_decode.sv
// ----------------------------------------------------------------------------
// mips_ex_decode
// Instruction decoder: turns an instruction word into the control word.
// Unsupported encodings give an all-clear control word with illegal set.
// ----------------------------------------------------------------------------
module mips_ex_decode (
  input  logic [31:0]          instr_i,
  output mips_ex_pkg::ctrl_t   ctrl_o
);
  import mips_ex_pkg::*;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_SRAV = 6'h07;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [4:0] LINK_REG = 5'd31;

  logic [5:0] op;
  logic [5:0] fn;
  logic [4:0] rt;
  logic [4:0] rd;
  ctrl_t      idle_ctrl;
  ctrl_t      ctrl;

  assign op = instr_i[31:26];
  assign fn = instr_i[5:0];
  assign rt = instr_i[20:16];
  assign rd = instr_i[15:11];

  always_comb begin
    idle_ctrl             = '0;
    idle_ctrl.alu_op      = ALU_NONE;
    idle_ctrl.opb         = OPB_RT;
    idle_ctrl.mem_op      = MEM_NONE;
    idle_ctrl.mem_size    = SIZE_BYTE;
    idle_ctrl.flow        = FLOW_NONE;
  end

  always_comb begin
    ctrl = idle_ctrl;
    case (op)
      OP_SPECIAL: begin
        ctrl.dest_reg  = rd;
        ctrl.reg_write = 1'b1;
        case (fn)
          FN_ADD, FN_ADDU: ctrl.alu_op = ALU_ADD;
          FN_SUB, FN_SUBU: ctrl.alu_op = ALU_SUB;
          FN_AND:  ctrl.alu_op = ALU_AND;
          FN_OR:   ctrl.alu_op = ALU_OR;
          FN_XOR:  ctrl.alu_op = ALU_XOR;
          FN_NOR:  ctrl.alu_op = ALU_NOR;
          FN_SLL:  ctrl.alu_op = ALU_SLL;
          FN_SRL:  ctrl.alu_op = ALU_SRL;
          FN_SRA:  ctrl.alu_op = ALU_SRA;
          FN_SLLV: begin
            ctrl.alu_op    = ALU_SLL;
            ctrl.shift_var = 1'b1;
          end
          FN_SRLV: begin
            ctrl.alu_op    = ALU_SRL;
            ctrl.shift_var = 1'b1;
          end
          FN_SRAV: begin
            ctrl.alu_op    = ALU_SRA;
            ctrl.shift_var = 1'b1;
          end
          FN_SLT:  ctrl.alu_op = ALU_SLT;
          FN_SLTU: ctrl.alu_op = ALU_SLTU;
          FN_JR: begin
            ctrl.dest_reg  = '0;
            ctrl.reg_write = 1'b0;
            ctrl.flow      = FLOW_JREG;
          end
          FN_JALR: begin
            ctrl.alu_op = ALU_LINK;
            ctrl.flow   = FLOW_JREG;
          end
          default: ctrl.illegal = 1'b1;
        endcase
      end
      OP_ADDI, OP_ADDIU: begin
        ctrl.alu_op = ALU_ADD;
        ctrl.opb    = OPB_SIMM;
      end
      OP_ANDI: begin
        ctrl.alu_op = ALU_AND;
        ctrl.opb    = OPB_ZIMM;
      end
      OP_ORI: begin
        ctrl.alu_op = ALU_OR;
        ctrl.opb    = OPB_ZIMM;
      end
      OP_XORI: begin
        ctrl.alu_op = ALU_XOR;
        ctrl.opb    = OPB_ZIMM;
      end
      OP_SLTI: begin
        ctrl.alu_op = ALU_SLT;
        ctrl.opb    = OPB_SIMM;
      end
      OP_SLTIU: begin
        ctrl.alu_op = ALU_SLTU;
        ctrl.opb    = OPB_SIMM;
      end
      OP_LUI: begin
        ctrl.alu_op = ALU_PASSB;
        ctrl.opb    = OPB_LUI;
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        ctrl.mem_op      = MEM_LOAD;
        ctrl.load_signed = op inside {OP_LB, OP_LH};
        if (op == OP_LW) begin
          ctrl.mem_size = SIZE_WORD;
        end else if (op inside {OP_LH, OP_LHU}) begin
          ctrl.mem_size = SIZE_HALF;
        end else begin
          ctrl.mem_size = SIZE_BYTE;
        end
      end
      OP_SB: begin
        ctrl.mem_op   = MEM_STORE;
        ctrl.mem_size = SIZE_BYTE;
      end
      OP_SH: begin
        ctrl.mem_op   = MEM_STORE;
        ctrl.mem_size = SIZE_HALF;
      end
      OP_SW: begin
        ctrl.mem_op   = MEM_STORE;
        ctrl.mem_size = SIZE_WORD;
      end
      OP_BEQ: ctrl.flow = FLOW_BEQ;
      OP_BNE: ctrl.flow = FLOW_BNE;
      OP_J:   ctrl.flow = FLOW_JUMP;
      OP_JAL: begin
        ctrl.flow     = FLOW_JUMP;
        ctrl.alu_op   = ALU_LINK;
        ctrl.dest_reg = LINK_REG;
      end
      default: ctrl.illegal = 1'b1;
    endcase

    // I-type writers go to rt
    if (op != OP_SPECIAL && op != OP_JAL && ctrl.mem_op != MEM_STORE &&
        (ctrl.alu_op != ALU_NONE || ctrl.mem_op == MEM_LOAD)) begin
      ctrl.dest_reg = rt;
    end
    if (op == OP_JAL || (op != OP_SPECIAL && ctrl.dest_reg == rt &&
        (ctrl.alu_op != ALU_NONE || ctrl.mem_op == MEM_LOAD))) begin
      ctrl.reg_write = 1'b1;
    end

    if (ctrl.illegal) begin
      ctrl         = idle_ctrl;
      ctrl.illegal = 1'b1;
    end
  end

  assign ctrl_o = ctrl;

endmodule

### sim/mips_execute_stage_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_execute_stage_tb
// Self-checking bench for the MIPS32 execute stage. A table of directed
// instructions covers the corner cases, then about a thousand random
// instructions follow, mostly legal ones with random fields and operands.
// Each beat is checked in order, field by field, against a local decoder model
// or a typed row. The sender idles at random; the result side cannot stall.
// ----------------------------------------------------------------------------
module mips_execute_stage_tb;
  import mips_ex_pkg::*;

  localparam int unsigned RANDOM_BEATS   = 1024;
  localparam int unsigned PAUSE_EVERY    = 250;
  localparam int unsigned BURST_LEN      = 50;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 100;

  localparam logic [5:0] OP_SPECIAL  = 6'h00;
  localparam logic [5:0] OP_J        = 6'h02;
  localparam logic [5:0] OP_JAL      = 6'h03;
  localparam logic [5:0] OP_BEQ      = 6'h04;
  localparam logic [5:0] OP_BNE      = 6'h05;
  localparam logic [5:0] OP_ADDI     = 6'h08;
  localparam logic [5:0] OP_ADDIU    = 6'h09;
  localparam logic [5:0] OP_SLTI     = 6'h0A;
  localparam logic [5:0] OP_SLTIU    = 6'h0B;
  localparam logic [5:0] OP_ANDI     = 6'h0C;
  localparam logic [5:0] OP_ORI      = 6'h0D;
  localparam logic [5:0] OP_XORI     = 6'h0E;
  localparam logic [5:0] OP_LUI      = 6'h0F;
  localparam logic [5:0] OP_LB       = 6'h20;
  localparam logic [5:0] OP_LH       = 6'h21;
  localparam logic [5:0] OP_LW       = 6'h23;
  localparam logic [5:0] OP_LBU      = 6'h24;
  localparam logic [5:0] OP_LHU      = 6'h25;
  localparam logic [5:0] OP_SB       = 6'h28;
  localparam logic [5:0] OP_SH       = 6'h29;
  localparam logic [5:0] OP_SW       = 6'h2B;
  localparam logic [5:0] OP_RESERVED = 6'h3F;

  localparam logic [5:0] FN_SLL      = 6'h00;
  localparam logic [5:0] FN_RESERVED = 6'h01;
  localparam logic [5:0] FN_SRL      = 6'h02;
  localparam logic [5:0] FN_SRA      = 6'h03;
  localparam logic [5:0] FN_SLLV     = 6'h04;
  localparam logic [5:0] FN_SRLV     = 6'h06;
  localparam logic [5:0] FN_SRAV     = 6'h07;
  localparam logic [5:0] FN_JR       = 6'h08;
  localparam logic [5:0] FN_JALR     = 6'h09;
  localparam logic [5:0] FN_ADD      = 6'h20;
  localparam logic [5:0] FN_ADDU     = 6'h21;
  localparam logic [5:0] FN_SUB      = 6'h22;
  localparam logic [5:0] FN_SUBU     = 6'h23;
  localparam logic [5:0] FN_AND      = 6'h24;
  localparam logic [5:0] FN_OR       = 6'h25;
  localparam logic [5:0] FN_XOR      = 6'h26;
  localparam logic [5:0] FN_NOR      = 6'h27;
  localparam logic [5:0] FN_SLT      = 6'h2A;
  localparam logic [5:0] FN_SLTU     = 6'h2B;

  localparam logic [4:0] LINK_REG    = 5'd31;

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] result;
    logic [4:0]  dest_reg;
    logic        reg_write;
    mem_op_e     mem_op;
    mem_size_e   mem_size;
    logic        load_signed;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        redirect;
    logic [31:0] target_pc;
    logic        illegal;
  } exec_beat_t;

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] rs_data;
    logic [31:0] rt_data;
    logic [31:0] pc;
    logic        typed;
    exec_beat_t  want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] instruction_i = '0;
  logic [31:0] rs_data_i = '0;
  logic [31:0] rt_data_i = '0;
  logic [31:0] pc_i = '0;
  logic        done_o;
  logic [31:0] result_o;
  logic [4:0]  dest_reg_o;
  logic        reg_write_o;
  logic [1:0]  mem_op_o;
  logic [1:0]  mem_size_o;
  logic        load_signed_o;
  logic [31:0] mem_address_o;
  logic [31:0] store_data_o;
  logic        redirect_o;
  logic [31:0] target_pc_o;
  logic        illegal_o;

  exec_beat_t  outstanding_results[$];
  exec_beat_t  presented_beat = '0;
  stim_row_t   directed_rows[$];
  int unsigned beats_in = 0;
  int unsigned stall_cycles = 0;
  bit          failed = 1'b0;
  bit          back_to_back = 1'b0;

  logic [5:0] legal_functs [18] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
                                    FN_JR, FN_JALR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
                                    FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
  logic [5:0] legal_opcodes [20] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU,
                                     OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
                                     OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH,
                                     OP_SW};

  mips_execute_stage dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .instruction_i (instruction_i),
    .rs_data_i     (rs_data_i),
    .rt_data_i     (rt_data_i),
    .pc_i          (pc_i),
    .done_o        (done_o),
    .result_o      (result_o),
    .dest_reg_o    (dest_reg_o),
    .reg_write_o   (reg_write_o),
    .mem_op_o      (mem_op_o),
    .mem_size_o    (mem_size_o),
    .load_signed_o (load_signed_o),
    .mem_address_o (mem_address_o),
    .store_data_o  (store_data_o),
    .redirect_o    (redirect_o),
    .target_pc_o   (target_pc_o),
    .illegal_o     (illegal_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] j_word(logic [5:0] op, logic [25:0] index);
    return {op, index};
  endfunction

  // Decode and execute one instruction; fields that do not apply stay zero
  function automatic exec_beat_t execute_instr(logic [31:0] instr, logic [31:0] a,
                                               logic [31:0] b, logic [31:0] pc);
    exec_beat_t  r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] zimm;
    logic [31:0] simm;
    logic [31:0] pc4;
    op   = instr[31:26];
    fn   = instr[5:0];
    rt   = instr[20:16];
    rd   = instr[15:11];
    sh   = instr[10:6];
    zimm = {16'h0000, instr[15:0]};
    simm = {{16{instr[15]}}, instr[15:0]};
    pc4  = pc + 32'd4;
    r = '0;
    r.instr = instr;
    if (op == OP_SPECIAL) begin
      r.dest_reg  = rd;
      r.reg_write = 1'b1;
      case (fn)
        FN_ADD, FN_ADDU: r.result = a + b;
        FN_SUB, FN_SUBU: r.result = a - b;
        FN_AND:  r.result = a & b;
        FN_OR:   r.result = a | b;
        FN_XOR:  r.result = a ^ b;
        FN_NOR:  r.result = ~(a | b);
        FN_SLL:  r.result = b << sh;
        FN_SRL:  r.result = b >> sh;
        FN_SRA:  r.result = $signed(b) >>> sh;
        FN_SLLV: r.result = b << a[4:0];
        FN_SRLV: r.result = b >> a[4:0];
        FN_SRAV: r.result = $signed(b) >>> a[4:0];
        FN_SLT:  r.result = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: r.result = {31'd0, a < b};
        FN_JR: begin
          r.reg_write = 1'b0;
          r.dest_reg  = '0;
          r.redirect  = 1'b1;
          r.target_pc = a;
        end
        FN_JALR: begin
          r.result    = pc4;
          r.redirect  = 1'b1;
          r.target_pc = a;
        end
        default: r.illegal = 1'b1;
      endcase
    end else begin
      case (op)
        OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI, OP_SLTIU, OP_LUI: begin
          r.dest_reg  = rt;
          r.reg_write = 1'b1;
          case (op)
            OP_ANDI:  r.result = a & zimm;
            OP_ORI:   r.result = a | zimm;
            OP_XORI:  r.result = a ^ zimm;
            OP_SLTI:  r.result = {31'd0, $signed(a) < $signed(simm)};
            OP_SLTIU: r.result = {31'd0, a < simm};
            OP_LUI:   r.result = {instr[15:0], 16'h0000};
            default:  r.result = a + simm;
          endcase
        end
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
          r.dest_reg    = rt;
          r.reg_write   = 1'b1;
          r.mem_op      = MEM_LOAD;
          r.mem_address = a + simm;
          r.load_signed = (op == OP_LB) || (op == OP_LH);
          if (op == OP_LW) r.mem_size = SIZE_WORD;
          else if (op == OP_LH || op == OP_LHU) r.mem_size = SIZE_HALF;
          else r.mem_size = SIZE_BYTE;
        end
        OP_SB, OP_SH, OP_SW: begin
          r.mem_op      = MEM_STORE;
          r.mem_address = a + simm;
          if (op == OP_SB) begin
            r.mem_size   = SIZE_BYTE;
            r.store_data = {24'd0, b[7:0]};
          end else if (op == OP_SH) begin
            r.mem_size   = SIZE_HALF;
            r.store_data = {16'd0, b[15:0]};
          end else begin
            r.mem_size   = SIZE_WORD;
            r.store_data = b;
          end
        end
        OP_BEQ, OP_BNE: begin
          // target is reported even when the branch falls through
          r.target_pc = pc4 + (simm << 2);
          r.redirect  = ((a == b) == (op == OP_BEQ));
        end
        OP_J, OP_JAL: begin
          r.redirect  = 1'b1;
          r.target_pc = {pc4[31:28], instr[25:0], 2'b00};
          if (op == OP_JAL) begin
            r.result    = pc4;
            r.dest_reg  = LINK_REG;
            r.reg_write = 1'b1;
          end
        end
        default: r.illegal = 1'b1;
      endcase
    end
    if (r.illegal) begin
      r = '0;
      r.instr   = instr;
      r.illegal = 1'b1;
    end
    return r;
  endfunction

  // Operands lean on the corners of the 32-bit range
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(0, 63));
      default: return $urandom();
    endcase
  endfunction

  function automatic stim_row_t mk_row(logic [31:0] instr, logic [31:0] a, logic [31:0] b,
                                       logic [31:0] pc);
    stim_row_t r;
    r.instr      = instr;
    r.rs_data    = a;
    r.rt_data    = b;
    r.pc         = pc;
    r.typed      = 1'b0;
    r.want       = '0;
    r.want.instr = instr;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] instr, logic [31:0] want,
                             logic [31:0] got);
    if (got !== want) begin
      failed = 1'b1;
      $display("%0t: %s mismatch on instruction %h: expected %h, got %h",
               $time, name, instr, want, got);
    end
  endtask

  task automatic check_result(exec_beat_t want);
    check_field("result", want.instr, want.result, result_o);
    check_field("dest_reg", want.instr, 32'(want.dest_reg), 32'(dest_reg_o));
    check_field("reg_write", want.instr, 32'(want.reg_write), 32'(reg_write_o));
    check_field("mem_op", want.instr, 32'(want.mem_op), 32'(mem_op_o));
    check_field("mem_size", want.instr, 32'(want.mem_size), 32'(mem_size_o));
    check_field("load_signed", want.instr, 32'(want.load_signed), 32'(load_signed_o));
    check_field("mem_address", want.instr, want.mem_address, mem_address_o);
    check_field("store_data", want.instr, want.store_data, store_data_o);
    check_field("redirect", want.instr, 32'(want.redirect), 32'(redirect_o));
    check_field("target_pc", want.instr, want.target_pc, target_pc_o);
    check_field("illegal", want.instr, 32'(want.illegal), 32'(illegal_o));
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(logic [31:0] instr, logic [31:0] a, logic [31:0] b,
                           logic [31:0] pc, exec_beat_t want);
    int unsigned gap;
    int unsigned seen;
    gap = back_to_back ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i       <= 1'b1;
    instruction_i <= instr;
    rs_data_i     <= a;
    rt_data_i     <= b;
    pc_i          <= pc;
    presented_beat = want;
    seen = beats_in;
    do @(negedge clk_i); while (beats_in == seen);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beats_in <= 0;
    end else begin
      if (done_o) begin
        if (outstanding_results.size() == 0) begin
          failed = 1'b1;
          $display("%0t: result beat with nothing outstanding, result %h", $time, result_o);
        end else begin
          check_result(outstanding_results.pop_front());
        end
      end
      if (start_i && !busy_o) begin
        outstanding_results.push_back(presented_beat);
        beats_in <= beats_in + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((start_i && !busy_o) || done_o)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("mips_execute_stage_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    exec_beat_t  want;
    logic [31:0] word;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned sel;

    // sll r0, r0, 0 still counts as a register write
    row = mk_row(32'h0000_0000, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
    row.typed = 1'b1;
    row.want.reg_write = 1'b1;
    directed_rows.push_back(row);
    // addu wraps without trapping
    row = mk_row(r_word(FN_ADDU, 5'd1, 5'd2, 5'd3, 5'd0), 32'hFFFF_FFFF, 32'h1, 32'h100);
    row.typed = 1'b1;
    row.want.dest_reg  = 5'd3;
    row.want.reg_write = 1'b1;
    directed_rows.push_back(row);
    // add with a non-zero shamt, signed overflow
    directed_rows.push_back(mk_row(r_word(FN_ADD, 5'd4, 5'd5, 5'd6, 5'd7),
                                   32'h7FFF_FFFF, 32'h1, 32'h104));
    directed_rows.push_back(mk_row(r_word(FN_SUB, 5'd0, 5'd1, 5'd31, 5'd0),
                                   32'h0, 32'h1, 32'h108));
    directed_rows.push_back(mk_row(r_word(FN_NOR, 5'd0, 5'd0, 5'd8, 5'd0),
                                   32'h0, 32'h0, 32'h10C));
    directed_rows.push_back(mk_row(r_word(FN_SRA, 5'd0, 5'd9, 5'd10, 5'd31),
                                   32'h5555_5555, 32'h8000_0000, 32'h110));
    directed_rows.push_back(mk_row(r_word(FN_SRLV, 5'd11, 5'd12, 5'd13, 5'd0),
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h114));
    // shift amount 32 wraps to zero
    directed_rows.push_back(mk_row(r_word(FN_SLLV, 5'd14, 5'd15, 5'd16, 5'd0),
                                   32'h0000_0020, 32'hA5A5_A5A5, 32'h118));
    directed_rows.push_back(mk_row(r_word(FN_SLT, 5'd17, 5'd18, 5'd19, 5'd0),
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h11C));
    directed_rows.push_back(mk_row(r_word(FN_SLTU, 5'd17, 5'd18, 5'd20, 5'd0),
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h120));
    // jr with junk in the fields that should be zero
    directed_rows.push_back(mk_row(r_word(FN_JR, 5'd31, 5'd7, 5'd9, 5'd3),
                                   32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h124));
    // jalr linking into r0, link address wraps
    directed_rows.push_back(mk_row(r_word(FN_JALR, 5'd2, 5'd0, 5'd0, 5'd0),
                                   32'h0000_0004, 32'h0, 32'hFFFF_FFFC));
    row = mk_row(r_word(FN_RESERVED, 5'd31, 5'd31, 5'd31, 5'd31),
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    row.typed = 1'b1;
    row.want.illegal = 1'b1;
    directed_rows.push_back(row);
    row = mk_row({OP_RESERVED, 26'h3FF_FFFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    row.typed = 1'b1;
    row.want.illegal = 1'b1;
    directed_rows.push_back(row);
    directed_rows.push_back(mk_row(i_word(OP_ADDI, 5'd1, 5'd2, 16'h8000),
                                   32'h0, 32'h0, 32'h200));
    // logical immediates are zero-extended
    directed_rows.push_back(mk_row(i_word(OP_ANDI, 5'd3, 5'd4, 16'hFFFF),
                                   32'hFFFF_FFFF, 32'h0, 32'h204));
    // sltiu sign-extends, then compares unsigned
    directed_rows.push_back(mk_row(i_word(OP_SLTIU, 5'd5, 5'd6, 16'hFFFF),
                                   32'hFFFF_FFFE, 32'h0, 32'h208));
    directed_rows.push_back(mk_row(i_word(OP_LUI, 5'd0, 5'd0, 16'hFFFF),
                                   32'h1234_5678, 32'h0, 32'h20C));
    directed_rows.push_back(mk_row(i_word(OP_LB, 5'd7, 5'd8, 16'hFFFF),
                                   32'h0, 32'hFFFF_FFFF, 32'h210));
    directed_rows.push_back(mk_row(i_word(OP_LHU, 5'd9, 5'd10, 16'h0001),
                                   32'hFFFF_FFFF, 32'h0, 32'h214));
    directed_rows.push_back(mk_row(i_word(OP_SB, 5'd11, 5'd12, 16'h7FFF),
                                   32'h8000_0000, 32'hFFFF_FFFF, 32'h218));
    directed_rows.push_back(mk_row(i_word(OP_SH, 5'd13, 5'd14, 16'h0000),
                                   32'h0, 32'hFFFF_FFFF, 32'h21C));
    directed_rows.push_back(mk_row(i_word(OP_BEQ, 5'd1, 5'd2, 16'h8000),
                                   32'h5, 32'h5, 32'hFFFF_FFFC));
    // fall-through still carries its target
    directed_rows.push_back(mk_row(i_word(OP_BNE, 5'd1, 5'd2, 16'h7FFF),
                                   32'h0, 32'h0, 32'h0));
    directed_rows.push_back(mk_row(j_word(OP_J, 26'h3FF_FFFF),
                                   32'h0, 32'h0, 32'hEFFF_FFFC));
    directed_rows.push_back(mk_row(j_word(OP_JAL, 26'h000_0000),
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFC));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      want = row.typed ? row.want
                       : execute_instr(row.instr, row.rs_data, row.rt_data, row.pc);
      send_beat(row.instr, row.rs_data, row.rt_data, row.pc, want);
    end

    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      if (n % PAUSE_EVERY == 0) begin
        // hold off until the pipe has emptied
        start_i <= 1'b0;
        do @(negedge clk_i); while (outstanding_results.size() != 0);
      end
      if (n % BURST_LEN == 0) back_to_back = ($urandom_range(0, 2) == 0);
      word = $urandom();
      sel  = $urandom_range(0, 99);
      if (sel < 40) begin
        word[31:26] = OP_SPECIAL;
        word[5:0]   = legal_functs[$urandom_range(0, 17)];
      end else if (sel < 90) begin
        word[31:26] = legal_opcodes[$urandom_range(0, 19)];
      end
      a = pick_operand();
      // equal operands often enough to take beq and skip bne
      b = ($urandom_range(0, 3) == 0) ? a : pick_operand();
      sel = pick_operand();
      send_beat(word, a, b, sel, execute_instr(word, a, b, sel));
    end

    start_i <= 1'b0;
    do @(negedge clk_i); while (outstanding_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (!failed) $display("mips_execute_stage_tb passed");
    else $display("mips_execute_stage_tb failed");
    $finish;
  end

endmodule

### filelist.f
rtl/mips_ex_pkg.sv
rtl/mips_ex_decode.sv
rtl/mips_execute_stage.sv
sim/mips_execute_stage_tb.sv
